// ----- rtl/core/sose_pkg.sv -----
package sose_pkg;

   // register indexes on the configuration port
   localparam logic CSR_IR_THRESHOLD = 1'b0;
   localparam logic CSR_ANGLE_STEP   = 1'b1;

   // configuration reset values
   localparam logic [9:0] IR_THRESHOLD_RESET = 10'd70;
   localparam logic [2:0] ANGLE_STEP_RESET   = 3'd2;

   // field limits
   localparam logic [5:0] OBJ_COUNT_MAX = 6'd63;
   localparam int         ANG_FULL_W    = 11;
   localparam int         RAD_W         = 24;
   localparam int         ROOT_STEPS    = RAD_W / 2;

   // work queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // round(32768 * cos(k deg)), k = 0..90
   localparam logic [15:0] COS_Q15 [0:90] = '{
      16'd32768, 16'd32763, 16'd32748, 16'd32723, 16'd32688, 16'd32643, 16'd32588,
      16'd32524, 16'd32449, 16'd32365, 16'd32270, 16'd32166, 16'd32052, 16'd31928,
      16'd31795, 16'd31651, 16'd31499, 16'd31336, 16'd31164, 16'd30983, 16'd30792,
      16'd30592, 16'd30382, 16'd30163, 16'd29935, 16'd29698, 16'd29452, 16'd29197,
      16'd28932, 16'd28660, 16'd28378, 16'd28088, 16'd27789, 16'd27482, 16'd27166,
      16'd26842, 16'd26510, 16'd26170, 16'd25822, 16'd25466, 16'd25102, 16'd24730,
      16'd24351, 16'd23965, 16'd23571, 16'd23170, 16'd22763, 16'd22348, 16'd21926,
      16'd21498, 16'd21063, 16'd20622, 16'd20174, 16'd19720, 16'd19261, 16'd18795,
      16'd18324, 16'd17847, 16'd17364, 16'd16877, 16'd16384, 16'd15886, 16'd15384,
      16'd14876, 16'd14365, 16'd13848, 16'd13328, 16'd12803, 16'd12275, 16'd11743,
      16'd11207, 16'd10668, 16'd10126, 16'd9580,  16'd9032,  16'd8481,  16'd7927,
      16'd7371,  16'd6813,  16'd6252,  16'd5690,  16'd5126,  16'd4560,  16'd3993,
      16'd3425,  16'd2856,  16'd2286,  16'd1715,  16'd1144,  16'd572,   16'd0
   };

   // one closed object handed from front to back
   typedef struct packed {
      logic [5:0]            object_number;
      logic [9:0]            center_distance;
      logic [7:0]            angular_width;
      logic [7:0]            center_angle;
      logic [ANG_FULL_W-1:0] width_deg;
      logic [9:0]            edge_a;
      logic [9:0]            edge_b;
   } job_type;

   // saturate an angle to eight bits
   function automatic logic [7:0] sat8(input logic [ANG_FULL_W-1:0] value);
      logic [7:0] result;
      if (value > ANG_FULL_W'(255)) result = 8'd255;
      else result = value[7:0];
      return result;
   endfunction

   // cosine in Q1.15, angle reduced mod 360 and folded
   function automatic logic signed [16:0] cos_q15(input logic [ANG_FULL_W-1:0] deg);
      logic [ANG_FULL_W-1:0] a;
      logic [6:0]            k;
      logic signed [16:0]    result;
      a = deg;
      for (int i = 0; i < 6; i++) begin
         if (a >= ANG_FULL_W'(360)) a = a - ANG_FULL_W'(360);
      end
      if (a > ANG_FULL_W'(180)) a = ANG_FULL_W'(360) - a;
      if (a > ANG_FULL_W'(90)) begin
         k = 7'(ANG_FULL_W'(180) - a);
         result = -$signed({1'b0, COS_Q15[k]});
      end else begin
         k = a[6:0];
         result = $signed({1'b0, COS_Q15[k]});
      end
      return result;
   endfunction

endpackage

// ----- rtl/core/sose_ram.sv -----
module sose_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data <= mem_ff[rd_addr];
   end

endmodule

// ----- rtl/core/sose_front.sv -----
module sose_front #(
   parameter int SWEEP_DEPTH = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [23:0]       req_tdata,   // ir_distance, sonar_distance
   input  logic              req_tuser,   // sweep_start
   input  logic [9:0]        ir_threshold,
   input  logic [2:0]        angle_step,
   input  logic              q_full,
   output logic              q_push,
   output sose_pkg::job_type q_job
);

   localparam int IDX_W = $clog2(SWEEP_DEPTH);
   localparam int ANG_W = IDX_W + 3;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SWEEP_DEPTH - 1);

   logic [9:0]       ir;
   logic [9:0]       sonar;
   logic             first;
   logic             accept;
   logic [IDX_W-1:0] idx;
   logic             open_hit;
   logic             close_hit;
   logic [IDX_W:0]   mid_sum;
   logic [IDX_W-1:0] mid;
   logic [ANG_W-1:0] a0;
   logic [ANG_W-1:0] a1;
   logic [ANG_W-1:0] width;
   logic [ANG_W:0]   angle_sum;
   logic [9:0]       ram_rd_data;

   logic [9:0]       prev_ir_ff;
   logic             inside_ff;
   logic [IDX_W-1:0] start_index_ff;
   logic [9:0]       start_sonar_ff;
   logic [5:0]       count_ff;
   logic [IDX_W-1:0] sample_index_ff;
   logic             pend_ff;
   logic             bypass_ff;
   logic [9:0]       bypass_data_ff;
   sose_pkg::job_type job_ff;

   // unpack the input word
   assign ir     = req_tdata[9:0];
   assign sonar  = req_tdata[19:10];
   assign first  = req_tuser;
   assign req_tready = !pend_ff && !q_full;
   assign accept = req_tvalid && req_tready;

   // classify the sample
   assign idx       = first ? '0 : sample_index_ff;
   assign open_hit  = !first && (prev_ir_ff > ir_threshold) && (ir <= ir_threshold) && !inside_ff;
   assign close_hit = !first && (prev_ir_ff < ir_threshold) && (ir >= ir_threshold) && inside_ff;

   // middle index and angles of the closing object
   assign mid_sum   = {1'b0, start_index_ff} + {1'b0, idx};
   assign mid       = mid_sum[IDX_W:1];
   assign a0        = ANG_W'(start_index_ff) * ANG_W'(angle_step);
   assign a1        = ANG_W'(idx) * ANG_W'(angle_step);
   assign width     = (a1 >= a0) ? (a1 - a0) : '0;
   assign angle_sum = {1'b0, a0} + {1'b0, a1};

   // sonar store
   sose_ram #(
      .WIDTH (10),
      .DEPTH (SWEEP_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (idx),
      .wr_data (sonar),
      .rd_en   (accept && close_hit),
      .rd_addr (mid),
      .rd_data (ram_rd_data)
   );

   // tracking state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ir_ff      <= '0;
         inside_ff       <= 1'b0;
         start_index_ff  <= '0;
         start_sonar_ff  <= '0;
         count_ff        <= '0;
         sample_index_ff <= '0;
      end else if (accept) begin
         prev_ir_ff      <= ir;
         sample_index_ff <= (idx < LAST_IDX) ? idx + 1'b1 : idx;
         if (first) begin
            count_ff  <= '0;
            inside_ff <= 1'b0;
         end else if (open_hit) begin
            if (count_ff != sose_pkg::OBJ_COUNT_MAX) count_ff <= count_ff + 1'b1;
            start_index_ff <= idx;
            start_sonar_ff <= sonar;
            inside_ff      <= 1'b1;
         end else if (close_hit) begin
            inside_ff <= 1'b0;
         end
      end
   end

   // pending close waits for the registered store read
   always_ff @(posedge clock) begin
      if (reset) pend_ff <= 1'b0;
      else pend_ff <= accept && close_hit;
   end

   // close payload
   always_ff @(posedge clock) begin
      if (accept && close_hit) begin
         job_ff.object_number   <= count_ff;
         job_ff.center_distance <= '0;
         job_ff.angular_width   <= sose_pkg::sat8(sose_pkg::ANG_FULL_W'(width));
         job_ff.center_angle    <= sose_pkg::sat8(sose_pkg::ANG_FULL_W'(angle_sum[ANG_W:1]));
         job_ff.width_deg       <= sose_pkg::ANG_FULL_W'(width);
         job_ff.edge_a          <= start_sonar_ff;
         job_ff.edge_b          <= sonar;
         bypass_ff              <= (mid == idx);
         bypass_data_ff         <= sonar;
      end
   end

   // hand the object to the queue
   assign q_push = pend_ff;
   always_comb begin
      q_job = job_ff;
      q_job.center_distance = bypass_ff ? bypass_data_ff : ram_rd_data;
   end

endmodule

// ----- rtl/core/sose_queue.sv -----
module sose_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  sose_pkg::job_type push_job,
   input  logic              pop,
   output sose_pkg::job_type head_job,
   output logic              full,
   output logic              empty
);

   sose_pkg::job_type entries_ff [sose_pkg::QUEUE_DEPTH];
   logic [sose_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff;
   logic [sose_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff;
   logic [sose_pkg::QUEUE_CNT_W-1:0] count_ff;

   assign full     = (count_ff == sose_pkg::QUEUE_CNT_W'(sose_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = entries_ff[rd_ptr_ff];

   // pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop) count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= push_job;
   end

endmodule

// ----- rtl/core/sose_back.sv -----
module sose_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_empty,
   input  sose_pkg::job_type q_head,
   output logic              q_pop,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [47:0]       rsp_tdata
);

   typedef enum logic [5:0] {
      S_IDLE = 6'b000001,
      S_MUL  = 6'b000010,
      S_PROD = 6'b000100,
      S_DIFF = 6'b001000,
      S_ROOT = 6'b010000,
      S_OUT  = 6'b100000
   } back_state_type;

   back_state_type state_ff;
   back_state_type state_in;

   sose_pkg::job_type   job_ff;
   logic [19:0]         aa_ff;
   logic [19:0]         bb_ff;
   logic [19:0]         ab_ff;
   logic signed [16:0]  cos_ff;
   logic [20:0]         sum_ff;
   logic signed [37:0]  t_ff;
   logic [sose_pkg::RAD_W-1:0] rad_ff;
   logic [14:0]         rem_ff;
   logic [11:0]         root_ff;
   logic [3:0]          step_ff;

   logic signed [39:0]  q_val;
   logic [14:0]         rem_shift;
   logic [14:0]         trial;
   logic                take;
   logic                last_step;

   // remainder of the cosine law, clamped at zero later
   assign q_val = $signed({4'b0000, sum_ff, 15'd0}) - $signed({t_ff[37], t_ff, 1'b0});

   // one root digit per cycle
   assign rem_shift = {rem_ff[12:0], rad_ff[sose_pkg::RAD_W-1 -: 2]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign take      = (rem_shift >= trial);
   assign last_step = (step_ff == 4'(sose_pkg::ROOT_STEPS - 1));

   assign q_pop      = (state_ff == S_IDLE) && !q_empty;
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {5'd0, job_ff.center_angle, root_ff[10:0], job_ff.angular_width,
                        job_ff.center_distance, job_ff.object_number};

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (!q_empty) state_in = S_MUL;
         S_MUL:  state_in = S_PROD;
         S_PROD: state_in = S_DIFF;
         S_DIFF: state_in = S_ROOT;
         S_ROOT: if (last_step) state_in = S_OUT;
         S_OUT:  if (rsp_tready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else state_ff <= state_in;
   end

   // datapath
   always_ff @(posedge clock) begin
      unique case (state_ff)
         S_IDLE: begin
            if (!q_empty) job_ff <= q_head;
         end
         S_MUL: begin
            aa_ff  <= job_ff.edge_a * job_ff.edge_a;
            bb_ff  <= job_ff.edge_b * job_ff.edge_b;
            ab_ff  <= job_ff.edge_a * job_ff.edge_b;
            cos_ff <= sose_pkg::cos_q15(job_ff.width_deg);
         end
         S_PROD: begin
            sum_ff <= {1'b0, aa_ff} + {1'b0, bb_ff};
            t_ff   <= $signed({1'b0, ab_ff}) * cos_ff;
         end
         S_DIFF: begin
            rad_ff  <= q_val[39] ? '0 : q_val[38:15];
            rem_ff  <= '0;
            root_ff <= '0;
            step_ff <= '0;
         end
         S_ROOT: begin
            rad_ff  <= {rad_ff[sose_pkg::RAD_W-3:0], 2'b00};
            step_ff <= step_ff + 1'b1;
            if (take) begin
               rem_ff  <= rem_shift - trial;
               root_ff <= {root_ff[10:0], 1'b1};
            end else begin
               rem_ff  <= rem_shift;
               root_ff <= {root_ff[10:0], 1'b0};
            end
         end
         S_OUT: begin
         end
         default: begin
         end
      endcase
   end

endmodule

// ----- rtl/core/sweep_object_segmenter.sv -----
// Throughput: one input word per cycle while the object queue is not full; a closing
// word stalls the input for the sonar store read. The back end works on one object
// at a time, through its multiply, product, difference, digit-by-digit square root
// and output states; a 2-entry queue absorbs bursts.
// Reset: synchronous, active high; clears tracking state, queue and sequencer and
// loads the threshold and step defaults. The sonar store is not cleared.
module sweep_object_segmenter #(
   parameter int SWEEP_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // [9:0] ir_distance, [19:10] sonar_distance
   input  logic        req_tuser,   // [0] sweep_start
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [5:0] object_number, [15:6] center_distance,
                                    // [23:16] angular_width, [34:24] width_cm,
                                    // [42:35] center_angle
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [9:0]  csr_data
);

   logic [9:0]        ir_threshold_ff;
   logic [2:0]        angle_step_ff;
   logic              q_full;
   logic              q_empty;
   logic              q_push;
   logic              q_pop;
   sose_pkg::job_type q_push_job;
   sose_pkg::job_type q_head_job;

   // configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ir_threshold_ff <= sose_pkg::IR_THRESHOLD_RESET;
         angle_step_ff   <= sose_pkg::ANGLE_STEP_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            sose_pkg::CSR_IR_THRESHOLD: ir_threshold_ff <= csr_data;
            sose_pkg::CSR_ANGLE_STEP:   angle_step_ff   <= csr_data[2:0];
            default: begin
            end
         endcase
      end
   end

   // sample classification
   sose_front #(
      .SWEEP_DEPTH (SWEEP_DEPTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .ir_threshold (ir_threshold_ff),
      .angle_step   (angle_step_ff),
      .q_full       (q_full),
      .q_push       (q_push),
      .q_job        (q_push_job)
   );

   // closed objects waiting for the back end
   sose_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_push_job),
      .pop      (q_pop),
      .head_job (q_head_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   // width computation and result word
   sose_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (q_head_job),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTHESIS
   a_accept_has_room: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |-> !q_full)
      else $error("input word accepted while the object queue is full");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("object pushed into a full queue");

   a_object_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[5:0] != 6'd0))
      else $error("result word carries object number zero");
`endif

endmodule
